// ===== src/multi_channel_limit_debouncer_unit_macros.svh =====
// Assertion macros for the limit debouncer.
// Needs clk and rst in the scope where a macro is used.
`ifndef MULTI_CHANNEL_LIMIT_DEBOUNCER_UNIT_MACROS_SVH
`define MULTI_CHANNEL_LIMIT_DEBOUNCER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCLD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mcld_pkg.sv =====
// Shared types and constants for the multi-channel limit debouncer.
// No dependencies; used by mcld_channel and the top level.
`timescale 1ns / 1ps

package mcld_pkg;

  localparam int MAX_CH       = 6;
  localparam int CHANNELS_DEF = 6;
  localparam int TIME_W       = 32;
  localparam int COUNT_W      = 32;
  localparam int DEBOUNCE_W   = 16;
  localparam int REQ_W        = 2;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [MAX_CH-1:0]     INVERT_RESET   = 6'd0;

  // Input word layout
  localparam int IN_RAW_LSB  = 0;
  localparam int IN_TIME_LSB = MAX_CH;
  localparam int IN_DATA_W   = 40;

  // Result word layout
  localparam int OUT_ACT_LSB   = 0;
  localparam int OUT_DEB_LSB   = MAX_CH;
  localparam int OUT_RAW_LSB   = 2 * MAX_CH;
  localparam int OUT_COUNT_LSB = 3 * MAX_CH;
  localparam int OUT_USED_W    = OUT_COUNT_LSB + MAX_CH * COUNT_W;
  localparam int OUT_DATA_W    = 216;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_INIT   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_INVERT   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                  load;
    logic                  sample;
    logic                  init;
    logic                  clear;
    logic [TIME_W-1:0]     now;
    logic [DEBOUNCE_W-1:0] debounce;
  } chan_cmd_t;

  typedef struct packed {
    logic               stored;
    logic               accepted;
    logic [COUNT_W-1:0] count;
  } chan_stat_t;

endpackage

// ===== src/mcld_channel.sv =====
// One debounce lane: stored raw bit, accepted level, hold stamp and edge counter.
// Depends on mcld_pkg for the command and status structs.
`timescale 1ns / 1ps

module mcld_channel (
  input  logic                  clk,
  input  logic                  rst,
  input  mcld_pkg::chan_cmd_t   cmd,
  input  logic                  raw,
  output mcld_pkg::chan_stat_t  stat
);

  logic                           stored;
  logic                           stored_next;
  logic                           accepted;
  logic                           accepted_next;
  logic [mcld_pkg::TIME_W-1:0]    stamp;
  logic [mcld_pkg::TIME_W-1:0]    stamp_next;
  logic [mcld_pkg::COUNT_W-1:0]   count;
  logic [mcld_pkg::COUNT_W-1:0]   count_next;
  logic                           changed;
  logic [mcld_pkg::TIME_W-1:0]    elapsed;
  logic                           take;

  assign changed = raw != stored;
  assign elapsed = changed ? '0 : cmd.now - stamp;
  assign take    = (elapsed >= {{(mcld_pkg::TIME_W - mcld_pkg::DEBOUNCE_W){1'b0}}, cmd.debounce})
                   && (accepted != raw);

  always_comb begin
    stored_next   = stored;
    accepted_next = accepted;
    stamp_next    = stamp;
    count_next    = count;
    if (cmd.init) begin
      stored_next   = raw;
      accepted_next = raw;
      stamp_next    = cmd.now;
      count_next    = '0;
    end else if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.sample) begin
      stored_next = raw;
      if (changed) begin
        stamp_next = cmd.now;
      end
      if (take) begin
        accepted_next = raw;
        count_next    = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored   <= 1'b0;
      accepted <= 1'b0;
      stamp    <= '0;
      count    <= '0;
    end else if (cmd.load) begin
      stored   <= stored_next;
      accepted <= accepted_next;
      stamp    <= stamp_next;
      count    <= count_next;
    end
  end

  assign stat.stored   = stored_next;
  assign stat.accepted = accepted_next;
  assign stat.count    = count_next;

endmodule

// ===== src/multi_channel_limit_debouncer_unit.sv =====
// Top level of the multi-channel limit debouncer: input register, debounce lanes,
// result register and configuration registers. Depends on mcld_pkg, mcld_channel
// and the assertion macros header.
`timescale 1ns / 1ps

// Each input word is a sample, an initialise or a clear-counts request with six raw
// pin levels and a millisecond timestamp; every word yields exactly one result word
// showing the state after it. Throughput is one word per clock cycle while the
// master side does not stall; each word moves from the input register into the
// result register once that is empty or being read. The cycle is set by each lane's
// 32-bit elapsed-time subtract and compare feeding its 32-bit edge counter, all
// between the input and result registers. Samples before the first initialise are
// ignored and the active levels read zero until then. Write configuration only
// while no words are in flight; the configuration port is always ready.

`include "multi_channel_limit_debouncer_unit_macros.svh"

module multi_channel_limit_debouncer_unit #(
  parameter int CHANNELS = mcld_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // raw_levels[5:0], time_ms[37:6], zero pad
  input  logic [mcld_pkg::IN_DATA_W-1:0]     s_tdata,
  // req_type[1:0]
  input  logic [mcld_pkg::REQ_W-1:0]         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // active_levels[5:0], debounced_levels[11:6], last_raw_levels[17:12],
  // count_ch0[49:18] .. count_ch5[209:178], zero pad
  output logic [mcld_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mcld_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mcld_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int MAX_CH  = mcld_pkg::MAX_CH;
  localparam int COUNT_W = mcld_pkg::COUNT_W;

  logic [mcld_pkg::DEBOUNCE_W-1:0] debounce_time;
  logic [MAX_CH-1:0]               invert_mask;

  logic                            in_valid;
  logic [mcld_pkg::REQ_W-1:0]      in_req;
  logic [MAX_CH-1:0]               in_raw;
  logic [mcld_pkg::TIME_W-1:0]     in_time;
  logic                            adv;

  logic                            ready_flag;
  logic                            ready_flag_next;
  mcld_pkg::chan_cmd_t             cmd;
  mcld_pkg::chan_stat_t            stat [MAX_CH];
  logic [MAX_CH-1:0]               deb_next;
  logic [MAX_CH-1:0]               raw_next;
  logic [MAX_CH-1:0]               lane_mask;

  logic [MAX_CH-1:0]               out_active;
  logic [MAX_CH-1:0]               out_deb;
  logic [MAX_CH-1:0]               out_raw;
  logic [COUNT_W-1:0]              out_count [MAX_CH];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= mcld_pkg::DEBOUNCE_RESET;
      invert_mask   <= mcld_pkg::INVERT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mcld_pkg::cfg_reg_t'(cfg_index))
        mcld_pkg::CFG_DEBOUNCE: debounce_time <= cfg_data;
        mcld_pkg::CFG_INVERT:   invert_mask   <= cfg_data[MAX_CH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= s_tuser;
      in_raw  <= s_tdata[mcld_pkg::IN_RAW_LSB +: MAX_CH];
      in_time <= s_tdata[mcld_pkg::IN_TIME_LSB +: mcld_pkg::TIME_W];
    end
  end

  // request decode
  always_comb begin
    cmd             = '0;
    cmd.load        = adv;
    cmd.now         = in_time;
    cmd.debounce    = debounce_time;
    ready_flag_next = ready_flag;
    if (adv) begin
      unique case (in_req)
        mcld_pkg::REQ_SAMPLE: cmd.sample = ready_flag;
        mcld_pkg::REQ_INIT: begin
          cmd.init        = 1'b1;
          ready_flag_next = 1'b1;
        end
        mcld_pkg::REQ_CLEAR:  cmd.clear = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flag <= 1'b0;
    end else begin
      ready_flag <= ready_flag_next;
    end
  end

  // lanes
  for (genvar i = 0; i < MAX_CH; i++) begin : g_lane
    if (i < CHANNELS) begin : g_used
      mcld_channel u_chan (
        .clk  (clk),
        .rst  (rst),
        .cmd  (cmd),
        .raw  (in_raw[i]),
        .stat (stat[i])
      );
      assign lane_mask[i] = 1'b1;
    end else begin : g_unused
      assign stat[i]      = '0;
      assign lane_mask[i] = 1'b0;
    end
    assign deb_next[i] = stat[i].accepted;
    assign raw_next[i] = stat[i].stored;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_active <= ready_flag_next ? ((deb_next ^ invert_mask) & lane_mask) : '0;
      out_deb    <= deb_next;
      out_raw    <= raw_next;
      for (int i = 0; i < MAX_CH; i++) begin
        out_count[i] <= stat[i].count;
      end
    end
  end

  assign m_tdata[mcld_pkg::OUT_ACT_LSB +: MAX_CH] = out_active;
  assign m_tdata[mcld_pkg::OUT_DEB_LSB +: MAX_CH] = out_deb;
  assign m_tdata[mcld_pkg::OUT_RAW_LSB +: MAX_CH] = out_raw;
  for (genvar i = 0; i < MAX_CH; i++) begin : g_count
    assign m_tdata[mcld_pkg::OUT_COUNT_LSB + i*COUNT_W +: COUNT_W] = out_count[i];
  end
  assign m_tdata[mcld_pkg::OUT_DATA_W-1:mcld_pkg::OUT_USED_W] = '0;

  `MCLD_ASSERT_NOW(a_ready_when_empty, !in_valid, s_tready, "input stage empty but not ready")
  `MCLD_ASSERT_NEXT(a_init_sets_ready, adv && in_req == mcld_pkg::REQ_INIT, ready_flag, "initialise did not set ready flag")
  `MCLD_ASSERT_NEXT(a_clear_zeroes, adv && in_req == mcld_pkg::REQ_CLEAR, m_tvalid && m_tdata[mcld_pkg::OUT_USED_W-1:mcld_pkg::OUT_COUNT_LSB] == '0, "clear left counts non-zero")
  `MCLD_ASSERT_NOW(a_inactive_before_init, m_tvalid && !ready_flag, out_active == '0, "active levels before initialise")

endmodule
